### rtl/ufct_pkg.sv
// Shared types and constants for the union-find cycle tracking block.
// Holds the node word layout and the controller-to-datapath command and status structs.
// No dependencies.
package ufct_pkg;

   // Node index width matches the request fields; the table covers every index
   localparam int NODE_W = 10;
   localparam int NODES  = 1 << NODE_W;

   // One table entry: cycle flag over parent link
   typedef struct packed {
      logic              mark;
      logic [NODE_W-1:0] link;
   } node_word_type;

   // Request function codes
   localparam logic FUNC_UNITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // Table read address source
   typedef enum logic [1:0] {
      RD_NONE,
      RD_ROOT,
      RD_CUR
   } rd_kind_type;

   // Table write operation
   typedef enum logic [2:0] {
      WR_NONE,
      WR_CLEAR,
      WR_COMPRESS,
      WR_CYCLE,
      WR_LINK_A,
      WR_LINK_B
   } wr_kind_type;

   // Controller commands to the datapath
   typedef struct packed {
      logic        load_req;
      logic        start_find;
      logic        side_b;
      logic        step_root;
      logic        save_root;
      logic        load_rsp;
      rd_kind_type rd_kind;
      wr_kind_type wr_kind;
   } dp_cmd_type;

   // Datapath status to the controller
   typedef struct packed {
      logic clr_done;
      logic root_hit;
      logic cur_at_root;
      logic is_query;
      logic same_root;
      logic rsp_full;
   } dp_status_type;

endpackage

### rtl/ufct_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on ufct_pkg for the node index width.
interface ufct_req_if;
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic [ufct_pkg::NODE_W-1:0]  node_a;
   logic [ufct_pkg::NODE_W-1:0]  node_b;

   modport source  (output valid, func, node_a, node_b, input ready);
   modport sink    (input valid, func, node_a, node_b, output ready);
endinterface

interface ufct_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         same_set;
   logic [ufct_pkg::NODE_W-1:0]  root_of_a;
   logic                         set_has_cycle;

   modport source  (output valid, same_set, root_of_a, set_has_cycle, input ready);
   modport sink    (input valid, same_set, root_of_a, set_has_cycle, output ready);
endinterface

### rtl/union_find_cycle_tracking.sv
// Top level of the union-find cycle tracking block.
// Joins ufct_ctrl and ufct_datapath; depends on ufct_pkg and the ufct_if channel interfaces.
//
//   channel   dir   handshake              payload
//   req_ch    in    req_ch.valid/ready     func, node_a, node_b
//   rsp_ch    out   rsp_ch.valid/ready     same_set, root_of_a, set_has_cycle
//
// After reset the node table is swept clear, one entry per cycle; no item is accepted
// until every entry is cleared. For an item the roots of node_a and node_b are found by
// following parent links, and each path is compressed to point at its root; a union of
// two sets then rewrites both roots. The node table does one read and one write a cycle,
// read data registered. The response register holds a result while the next item is
// accepted and walked; an item completes only once it is free.
module union_find_cycle_tracking (
   input  logic         clock,
   input  logic         reset,
   ufct_req_if.sink     req_ch,
   ufct_rsp_if.source   rsp_ch
);

   ufct_pkg::dp_cmd_type    cmd;
   ufct_pkg::dp_status_type status;

   ufct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ufct_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_func          (req_ch.func),
      .req_node_a        (req_ch.node_a),
      .req_node_b        (req_ch.node_b),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_same_set      (rsp_ch.same_set),
      .rsp_root_of_a     (rsp_ch.root_of_a),
      .rsp_set_has_cycle (rsp_ch.set_has_cycle)
   );

endmodule

### rtl/ufct_datapath.sv
// Datapath: node table memory, walk registers and the response register.
// Driven by ufct_ctrl through ufct_pkg::dp_cmd_type; depends on ufct_pkg.
module ufct_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  ufct_pkg::dp_cmd_type          cmd,
   output ufct_pkg::dp_status_type       status,
   input  logic                          req_func,
   input  logic [ufct_pkg::NODE_W-1:0]   req_node_a,
   input  logic [ufct_pkg::NODE_W-1:0]   req_node_b,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_same_set,
   output logic [ufct_pkg::NODE_W-1:0]   rsp_root_of_a,
   output logic                          rsp_set_has_cycle
);

   ufct_pkg::node_word_type        table_mem [ufct_pkg::NODES];
   ufct_pkg::node_word_type        rdata_ff;

   logic [ufct_pkg::NODE_W-1:0]    clr_cnt_ff;
   logic                           func_ff;
   logic [ufct_pkg::NODE_W-1:0]    node_a_ff;
   logic [ufct_pkg::NODE_W-1:0]    node_b_ff;
   logic [ufct_pkg::NODE_W-1:0]    root_ff;
   logic [ufct_pkg::NODE_W-1:0]    cur_ff;
   logic [ufct_pkg::NODE_W-1:0]    ra_ff;
   logic                           ma_ff;
   logic                           mb_ff;

   logic                           rsp_valid_ff;
   logic                           rsp_same_ff;
   logic [ufct_pkg::NODE_W-1:0]    rsp_root_ff;
   logic                           rsp_flag_ff;

   logic                           rd_en;
   logic [ufct_pkg::NODE_W-1:0]    rd_addr;
   logic                           wr_en;
   logic [ufct_pkg::NODE_W-1:0]    wr_addr;
   ufct_pkg::node_word_type        wr_data;
   logic                           same_root;
   logic                           mark_or;
   logic                           rsp_flag_in;
   logic [ufct_pkg::NODE_W-1:0]    rsp_root_in;

   assign same_root = (ra_ff == root_ff);
   assign mark_or   = ma_ff | mb_ff;

   // Select read address
   always_comb begin
      rd_en   = 1'b1;
      rd_addr = root_ff;
      unique case (cmd.rd_kind)
         ufct_pkg::RD_ROOT: rd_addr = root_ff;
         ufct_pkg::RD_CUR:  rd_addr = cur_ff;
         default:           rd_en   = 1'b0;
      endcase
   end

   // Select write address and data
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = cur_ff;
      wr_data = '{mark: rdata_ff.mark, link: root_ff};
      unique case (cmd.wr_kind)
         ufct_pkg::WR_CLEAR: begin
            wr_addr = clr_cnt_ff;
            wr_data = '{mark: 1'b0, link: clr_cnt_ff};
         end
         ufct_pkg::WR_COMPRESS: begin
            wr_addr = cur_ff;
            wr_data = '{mark: rdata_ff.mark, link: root_ff};
         end
         ufct_pkg::WR_CYCLE: begin
            wr_addr = ra_ff;
            wr_data = '{mark: 1'b1, link: ra_ff};
         end
         ufct_pkg::WR_LINK_A: begin
            wr_addr = ra_ff;
            wr_data = '{mark: mark_or, link: root_ff};
         end
         ufct_pkg::WR_LINK_B: begin
            wr_addr = root_ff;
            wr_data = '{mark: mark_or, link: root_ff};
         end
         default: wr_en = 1'b0;
      endcase
   end

   // Node table: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= table_mem[rd_addr];
      end
   end

   // Advance the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.wr_kind == ufct_pkg::WR_CLEAR) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // Hold the item and walk pointers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff   <= req_func;
         node_a_ff <= req_node_a;
         node_b_ff <= req_node_b;
      end
      if (cmd.start_find) begin
         root_ff <= cmd.side_b ? node_b_ff : node_a_ff;
         cur_ff  <= cmd.side_b ? node_b_ff : node_a_ff;
      end else begin
         if (cmd.step_root) begin
            root_ff <= rdata_ff.link;
         end
         if (cmd.wr_kind == ufct_pkg::WR_COMPRESS) begin
            cur_ff <= rdata_ff.link;
         end
      end
      if (cmd.save_root) begin
         if (cmd.side_b) begin
            mb_ff <= rdata_ff.mark;
         end else begin
            ra_ff <= root_ff;
            ma_ff <= rdata_ff.mark;
         end
      end
   end

   // Form the response from the roots and flags: side a's for a query, both for a union
   always_comb begin
      if (func_ff == ufct_pkg::FUNC_QUERY) begin
         rsp_root_in = ra_ff;
         rsp_flag_in = ma_ff;
      end else if (same_root) begin
         rsp_root_in = ra_ff;
         rsp_flag_in = 1'b1;
      end else begin
         rsp_root_in = root_ff;
         rsp_flag_in = mark_or;
      end
   end

   // Hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_same_ff <= same_root;
         rsp_root_ff <= rsp_root_in;
         rsp_flag_ff <= rsp_flag_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_same_set      = rsp_same_ff;
   assign rsp_root_of_a     = rsp_root_ff;
   assign rsp_set_has_cycle = rsp_flag_ff;

   assign status.clr_done    = (clr_cnt_ff == ufct_pkg::NODE_W'(ufct_pkg::NODES - 1));
   assign status.root_hit    = (rdata_ff.link == root_ff);
   assign status.cur_at_root = (cur_ff == root_ff);
   assign status.is_query    = (func_ff == ufct_pkg::FUNC_QUERY);
   assign status.same_root   = same_root;
   assign status.rsp_full    = rsp_valid_ff;

endmodule

### rtl/ufct_ctrl.sv
// Controller: sequences clearing, the two root walks with compression, and the union.
// Talks to ufct_datapath only through ufct_pkg command and status structs.
module ufct_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ufct_pkg::dp_status_type  status,
   output ufct_pkg::dp_cmd_type     cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_FIND_RD,
      S_FIND_CHK,
      S_COMP_RD,
      S_COMP_WR,
      S_FIN,
      S_LINK_B,
      S_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      side_ff;
   logic      side_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      side_in        = side_ff;
      cmd            = '0;
      cmd.side_b     = side_ff;
      cmd.rd_kind    = ufct_pkg::RD_NONE;
      cmd.wr_kind    = ufct_pkg::WR_NONE;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.wr_kind = ufct_pkg::WR_CLEAR;
            if (status.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               side_in      = 1'b0;
               state_in     = S_START;
            end
         end
         S_START: begin
            cmd.start_find = 1'b1;
            state_in       = S_FIND_RD;
         end
         S_FIND_RD: begin
            cmd.rd_kind = ufct_pkg::RD_ROOT;
            state_in    = S_FIND_CHK;
         end
         S_FIND_CHK: begin
            if (status.root_hit) begin
               cmd.save_root = 1'b1;
               state_in      = S_COMP_RD;
            end else begin
               cmd.step_root = 1'b1;
               state_in      = S_FIND_RD;
            end
         end
         S_COMP_RD: begin
            if (status.cur_at_root) begin
               if (side_ff) begin
                  state_in = S_FIN;
               end else begin
                  side_in  = 1'b1;
                  state_in = S_START;
               end
            end else begin
               cmd.rd_kind = ufct_pkg::RD_CUR;
               state_in    = S_COMP_WR;
            end
         end
         S_COMP_WR: begin
            cmd.wr_kind = ufct_pkg::WR_COMPRESS;
            state_in    = S_COMP_RD;
         end
         S_FIN: begin
            priority if (status.is_query) begin
               state_in = S_OUT;
            end else if (status.same_root) begin
               cmd.wr_kind = ufct_pkg::WR_CYCLE;
               state_in    = S_OUT;
            end else begin
               cmd.wr_kind = ufct_pkg::WR_LINK_A;
               state_in    = S_LINK_B;
            end
         end
         S_LINK_B: begin
            cmd.wr_kind = ufct_pkg::WR_LINK_B;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (!status.rsp_full) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state and walk side
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         side_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         side_ff  <= side_in;
      end
   end

endmodule

### rtl/ufct_checker.sv
// Port-level checks for union_find_cycle_tracking, attached with a bind.
// Depends on ufct_pkg for the node index width.
module ufct_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        rsp_same_set,
   input  logic [ufct_pkg::NODE_W-1:0] rsp_root_of_a,
   input  logic                        rsp_set_has_cycle
);

   // A stalled response item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response item keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_same_set) && $stable(rsp_root_of_a) &&
         $stable(rsp_set_has_cycle))
      else $error("response payload changed while stalled");

   // One item at a time: no accept in the cycle after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while an item is in progress");

   // Table sweep follows reset: no item is taken right after it
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready during table clearing");

endmodule

bind union_find_cycle_tracking ufct_checker u_ufct_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_same_set      (rsp_ch.same_set),
   .rsp_root_of_a     (rsp_ch.root_of_a),
   .rsp_set_has_cycle (rsp_ch.set_has_cycle)
);

### bench/union_find_cycle_tracking_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the union-find cycle tracking block: directed table, then random
// unite/query traffic scored against a local disjoint-set predictor. Depends on ufct_pkg, ufct_if.
module union_find_cycle_tracking_tb;

   localparam int RANDOM_ITEMS   = 1700;
   localparam int QUIET_STRETCH  = 200;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int DRAIN_CYCLES   = 40;

   // One result item as the block reports it
   typedef struct packed {
      logic                        same;
      logic [ufct_pkg::NODE_W-1:0] root;
      logic                        cyc;
   } outcome_type;

   // One row of the directed table; want is used only where known is set
   typedef struct packed {
      logic                        func;
      logic [ufct_pkg::NODE_W-1:0] node_a;
      logic [ufct_pkg::NODE_W-1:0] node_b;
      logic                        known;
      outcome_type                 want;
   } probe_row_type;

   localparam outcome_type NO_WANT = '{1'b0, 10'd0, 1'b0};

   // Reset view, extremes, self-union, flag merge, chain walks, alternating bit patterns
   probe_row_type directed_rows [23] = '{
      '{ufct_pkg::FUNC_QUERY,   10'd0, 10'd0,    1'b1, '{1'b1, 10'd0,    1'b0}},
      '{ufct_pkg::FUNC_QUERY, 10'd1023, 10'd1023, 1'b1, '{1'b1, 10'd1023, 1'b0}},
      '{ufct_pkg::FUNC_QUERY,   10'd0, 10'd1023, 1'b1, '{1'b0, 10'd0,    1'b0}},
      '{ufct_pkg::FUNC_UNITE,   10'd0, 10'd1023, 1'b1, '{1'b0, 10'd1023, 1'b0}},
      '{ufct_pkg::FUNC_UNITE, 10'd1023, 10'd0,   1'b1, '{1'b1, 10'd1023, 1'b1}},
      '{ufct_pkg::FUNC_QUERY,   10'd0, 10'd0,    1'b1, '{1'b1, 10'd1023, 1'b1}},
      '{ufct_pkg::FUNC_UNITE,   10'd5, 10'd5,    1'b1, '{1'b1, 10'd5,    1'b1}},
      '{ufct_pkg::FUNC_UNITE,   10'd5, 10'd6,    1'b0, NO_WANT},
      '{ufct_pkg::FUNC_UNITE,   10'd7, 10'd8,    1'b0, NO_WANT},
      '{ufct_pkg::FUNC_UNITE,   10'd8, 10'd9,    1'b0, NO_WANT},
      '{ufct_pkg::FUNC_UNITE,   10'd9, 10'd10,   1'b0, NO_WANT},
      '{ufct_pkg::FUNC_UNITE,  10'd10, 10'd11,   1'b0, NO_WANT},
      '{ufct_pkg::FUNC_QUERY,   10'd7, 10'd11,   1'b0, NO_WANT},
      '{ufct_pkg::FUNC_UNITE,  10'd11, 10'd6,    1'b0, NO_WANT},
      '{ufct_pkg::FUNC_QUERY,   10'd7, 10'd5,    1'b0, NO_WANT},
      '{ufct_pkg::FUNC_UNITE, 10'd682, 10'd341,  1'b1, '{1'b0, 10'd341,  1'b0}},
      '{ufct_pkg::FUNC_UNITE, 10'd341, 10'd682,  1'b1, '{1'b1, 10'd341,  1'b1}},
      '{ufct_pkg::FUNC_QUERY, 10'd682, 10'd1023, 1'b0, NO_WANT},
      '{ufct_pkg::FUNC_UNITE, 10'd512, 10'd1,    1'b0, NO_WANT},
      '{ufct_pkg::FUNC_QUERY,   10'd1, 10'd512,  1'b0, NO_WANT},
      '{ufct_pkg::FUNC_UNITE, 10'd1023, 10'd682, 1'b0, NO_WANT},
      '{ufct_pkg::FUNC_QUERY,   10'd0, 10'd5,    1'b0, NO_WANT},
      '{ufct_pkg::FUNC_UNITE,   10'd0, 10'd7,    1'b0, NO_WANT}
   };

   logic clock;
   logic reset;

   ufct_req_if req_ch ();
   ufct_rsp_if rsp_ch ();

   union_find_cycle_tracking DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Predictor copy of the node table
   logic [ufct_pkg::NODE_W-1:0] node_parent [ufct_pkg::NODES];
   logic                        node_flag   [ufct_pkg::NODES];

   outcome_type pending_outcomes [$];
   int          error_count;
   int          sent_count;
   int          total_items;
   logic        idle_on;
   logic        calm;
   int          quiet_cycles = 0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Follow parent links to the root, then relink every visited node straight to it
   function automatic logic [ufct_pkg::NODE_W-1:0] resolve_root(
         input logic [ufct_pkg::NODE_W-1:0] start);
      logic [ufct_pkg::NODE_W-1:0] top;
      logic [ufct_pkg::NODE_W-1:0] cur;
      logic [ufct_pkg::NODE_W-1:0] nxt;
      top = start;
      while (node_parent[top] != top) top = node_parent[top];
      cur = start;
      while (cur != top) begin
         nxt = node_parent[cur];
         node_parent[cur] = top;
         cur = nxt;
      end
      return top;
   endfunction

   // Apply one request to the predictor table and return the result item it yields
   function automatic outcome_type forest_step(input logic func,
                                               input logic [ufct_pkg::NODE_W-1:0] node_a,
                                               input logic [ufct_pkg::NODE_W-1:0] node_b);
      logic [ufct_pkg::NODE_W-1:0] root_a;
      logic [ufct_pkg::NODE_W-1:0] root_b;
      logic [ufct_pkg::NODE_W-1:0] top;
      outcome_type                 res;
      root_a   = resolve_root(node_a);
      root_b   = resolve_root(node_b);
      res.same = (root_a == root_b);
      top      = root_a;
      if (func == ufct_pkg::FUNC_UNITE) begin
         if (res.same) begin
            node_flag[root_a] = 1'b1;
         end else begin
            node_parent[root_a] = root_b;
            if (node_flag[root_a] || node_flag[root_b]) begin
               node_flag[root_a] = 1'b1;
               node_flag[root_b] = 1'b1;
            end
            top = root_b;
         end
      end
      res.root = top;
      res.cyc  = node_flag[top];
      return res;
   endfunction

   // Append one expected result item at the tail of the queue
   function automatic void queue_outcome(input outcome_type item);
      pending_outcomes = {pending_outcomes, item};
   endfunction

   // Drive one item, hold it until accepted, then queue its expected result
   task automatic send_request(input logic func, input logic [ufct_pkg::NODE_W-1:0] node_a,
                               input logic [ufct_pkg::NODE_W-1:0] node_b, input logic known,
                               input outcome_type want);
      outcome_type predicted;
      if ($urandom_range(0, 59) == 0) calm = ~calm;
      idle_on = !calm && (sent_count < total_items - QUIET_STRETCH);
      if (idle_on && $urandom_range(0, 2) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_ch.valid  = 1'b1;
      req_ch.func   = func;
      req_ch.node_a = node_a;
      req_ch.node_b = node_b;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predicted = forest_step(func, node_a, node_b);
      queue_outcome(known ? want : predicted);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic report_field(input string name, input int want, input int got);
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
   endtask

   // Stimulus
   initial begin
      int                          kind;
      int                          len;
      int                          window_base;
      logic [ufct_pkg::NODE_W-1:0] head;
      logic [ufct_pkg::NODE_W-1:0] prev;
      logic [ufct_pkg::NODE_W-1:0] nxt;

      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.func   = ufct_pkg::FUNC_UNITE;
      req_ch.node_a = '0;
      req_ch.node_b = '0;
      idle_on       = 1'b0;
      calm          = 1'b0;
      error_count   = 0;
      sent_count    = 0;
      total_items   = $size(directed_rows) + RANDOM_ITEMS;
      window_base   = 0;
      for (int i = 0; i < ufct_pkg::NODES; i++) begin
         node_parent[i] = i[ufct_pkg::NODE_W-1:0];
         node_flag[i]   = 1'b0;
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Walk the directed table
      foreach (directed_rows[i])
         send_request(directed_rows[i].func, directed_rows[i].node_a, directed_rows[i].node_b,
                      directed_rows[i].known, directed_rows[i].want);

      // Random traffic: link chains, local clusters, and scattered requests
      while (sent_count < total_items) begin
         kind = $urandom_range(0, 9);
         if ($urandom_range(0, 39) == 0)
            window_base = $urandom_range(0, ufct_pkg::NODES - 64);
         if (kind < 2) begin
            len  = $urandom_range(3, 24);
            head = ufct_pkg::NODE_W'($urandom_range(0, ufct_pkg::NODES - 1));
            prev = head;
            for (int k = 0; k < len; k++) begin
               nxt = ufct_pkg::NODE_W'($urandom_range(0, ufct_pkg::NODES - 1));
               send_request(ufct_pkg::FUNC_UNITE, prev, nxt, 1'b0, NO_WANT);
               prev = nxt;
            end
            send_request(ufct_pkg::FUNC_QUERY, head, prev, 1'b0, NO_WANT);
         end else if (kind < 6) begin
            send_request(1'($urandom_range(0, 1)),
                         ufct_pkg::NODE_W'(window_base + $urandom_range(0, 63)),
                         ufct_pkg::NODE_W'(window_base + $urandom_range(0, 63)),
                         1'b0, NO_WANT);
         end else begin
            send_request(1'($urandom_range(0, 1)),
                         ufct_pkg::NODE_W'($urandom_range(0, ufct_pkg::NODES - 1)),
                         ufct_pkg::NODE_W'($urandom_range(0, ufct_pkg::NODES - 1)),
                         1'b0, NO_WANT);
         end
      end
      req_ch.valid = 1'b0;

      // Drain outstanding results, then idle before ending the run
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Result side ready: random stall bursts while idling is on
   initial begin
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready = 1'b0;
            stall_left   = $urandom_range(0, 6);
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   // Score each accepted result against the oldest expectation
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            error_count++;
            $display("%0t: result with none expected, actual same=%0d root=%0d cycle=%0d",
                     $time, rsp_ch.same_set, rsp_ch.root_of_a, rsp_ch.set_has_cycle);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_ch.same_set !== want.same)
               report_field("same_set", want.same, rsp_ch.same_set);
            if (rsp_ch.root_of_a !== want.root)
               report_field("root_of_a", want.root, rsp_ch.root_of_a);
            if (rsp_ch.set_has_cycle !== want.cyc)
               report_field("set_has_cycle", want.cyc, rsp_ch.set_has_cycle);
         end
      end
   end

   // Watchdog: end the run if no item moves on either channel for too long
   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("tb: failure");
            $finish;
         end
      end
   end

endmodule
